FILE: hdl/tksk_pkg.sv
// Package for the top-K sorted keeper: item structs, operation codes and cell types.
// Standalone; used by tksk_cell and top_k_sorted_keeper.
package tksk_pkg;

	localparam int TKSK_DEPTH   = 16;
	localparam int SAMPLE_W     = 16;
	localparam int COUNT_OUT_W  = 5;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic                       func;
		logic signed [SAMPLE_W-1:0] sample_in;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] popped_value;
		logic                       status;
		logic [COUNT_OUT_W-1:0]     entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS_UP,
		CELL_INS_DOWN,
		CELL_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [SAMPLE_W-1:0] sample;
	} cell_ctl_t;

	typedef struct packed {
		logic                       le;
		logic signed [SAMPLE_W-1:0] value;
	} cell_link_t;

endpackage

FILE: hdl/tksk_cell.sv
// One cell of the sorted chain: holds a sample and trades it with its neighbours.
// Depends on tksk_pkg.
module tksk_cell
	import tksk_pkg::*;
(
	input  logic       clk,
	input  logic       occupied,
	input  cell_ctl_t  ctl,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link
);

	logic signed [SAMPLE_W-1:0] value_q;
	logic                       le;

	assign le         = occupied && (value_q <= ctl.sample);
	assign link.le    = le;
	assign link.value = value_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_HOLD: begin
				value_q <= value_q;
			end
			CELL_INS_UP: begin
				if (!le) begin
					value_q <= left.le ? ctl.sample : left.value;
				end
			end
			CELL_INS_DOWN: begin
				if (le) begin
					value_q <= right.le ? right.value : ctl.sample;
				end
			end
			CELL_SHIFT_DOWN: begin
				value_q <= right.value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

FILE: hdl/top_k_sorted_keeper.sv
// Top-K sorted keeper: a row of KEEP_DEPTH cells held in ascending order.
// The result item is registered and valid in the cycle after the input item is taken.
// Throughput: one item per cycle while rsp_ready is high; every cell compares against the sample in parallel.
// Reset clears the entry count and the result valid flag; cell contents are not cleared.
// Depends on tksk_pkg and tksk_cell.
module top_k_sorted_keeper
	import tksk_pkg::*;
#(
	parameter int KEEP_DEPTH = TKSK_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CW = $clog2(KEEP_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	cell_ctl_t     ctl;
	cell_link_t    links [KEEP_DEPTH];
	logic          accept;
	logic          full;
	logic          empty;
	logic          is_pop;

	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CW'(KEEP_DEPTH));
	assign empty     = (count_q == '0);
	assign is_pop    = (req.func == FUNC_POP);
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		ctl.sample = req.sample_in;
		ctl.op     = CELL_HOLD;
		count_d    = count_q;
		if (accept) begin
			if (is_pop) begin
				if (!empty) begin
					ctl.op  = CELL_SHIFT_DOWN;
					count_d = count_q - CW'(1);
				end
			end else if (!full) begin
				ctl.op  = CELL_INS_UP;
				count_d = count_q + CW'(1);
			end else if (links[0].le) begin
				ctl.op = CELL_INS_DOWN;
			end
		end
		rsp_d.popped_value = (is_pop && !empty) ? links[0].value : '0;
		rsp_d.status       = (is_pop && empty) ? STATUS_EMPTY : STATUS_OK;
		rsp_d.entry_count  = COUNT_OUT_W'(count_d);
	end

	genvar i;
	generate
		for (i = 0; i < KEEP_DEPTH; i++) begin : g_cell
			cell_link_t left_link;
			cell_link_t right_link;
			logic       occupied;

			assign occupied = (count_q > CW'(i));

			if (i == 0) begin : g_left_edge
				assign left_link.le    = 1'b1;
				assign left_link.value = '0;
			end else begin : g_left_link
				assign left_link = links[i-1];
			end

			if (i == KEEP_DEPTH - 1) begin : g_right_edge
				assign right_link.le    = 1'b0;
				assign right_link.value = '0;
			end else begin : g_right_link
				assign right_link = links[i+1];
			end

			tksk_cell u_cell (
				.clk      (clk),
				.occupied (occupied),
				.ctl      (ctl),
				.left     (left_link),
				.right    (right_link),
				.link     (links[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(KEEP_DEPTH))
		else $error("entry count above depth");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_pop && empty) |=> (rsp_valid && rsp.status == STATUS_EMPTY
			&& count_q == '0))
		else $error("pop on empty store not reported");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_pop && full) |=> full)
		else $error("insert into full store changed count");

	a_pop_value: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_pop && !empty) |=> (rsp.popped_value == $past(links[0].value)))
		else $error("popped value is not the minimum");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("item taken while result stalled");
`endif

endmodule
